FILE: design/bapp_pkg.sv
package bapp_pkg;

    localparam int MAX_STEPS_DEF = 1024;
    localparam int VAL_W         = 48;
    localparam int ACC_W         = 66;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam logic [31:0]      ONE_Q30 = 32'h4000_0000;

    // configuration register indexes
    localparam logic [2:0] REG_UP    = 3'd0;
    localparam logic [2:0] REG_DOWN  = 3'd1;
    localparam logic [2:0] REG_WUP   = 3'd2;
    localparam logic [2:0] REG_WDN   = 3'd3;
    localparam logic [2:0] REG_STEPS = 3'd4;

    typedef logic [VAL_W-1:0] t_val;

endpackage

FILE: design/bapp_ram.sv
module bapp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/binomial_american_put_pricer_unit.sv
// American put pricer on a recombining binomial lattice. Each s_ transfer
// carries one option (spot, strike); one m_ transfer returns its price, all
// Q16.32. The lattice constants u, d, p0, p1 and the step count N come from
// the APB registers and must only change while the unit is idle. The node
// values live in one single-port-read RAM of MAX_STEPS words; all products
// go through one shared 32x32 multiplier, for the spot scalings and for the
// node blends alike. One item is processed at a time; a new item is taken
// while the previous result still waits.
module binomial_american_put_pricer_unit
    import bapp_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // spot [47:0], strike [95:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // price [47:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_STEPS);
    localparam int CW = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCALE = 4'd1;
    localparam logic [3:0] S_LEAF  = 4'd2;
    localparam logic [3:0] S_LRD0  = 4'd3;
    localparam logic [3:0] S_L0    = 4'd4;
    localparam logic [3:0] S_NRD   = 4'd5;
    localparam logic [3:0] S_BL    = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    // config registers
    logic [31:0] r_up, r_wup, r_wdn;
    logic [30:0] r_down;
    logic [10:0] r_steps;

    logic [3:0]    r_state, r_ret;
    logic [2:0]    r_ph;
    logic          r_fsel;          // 1: up factor, 0: down factor
    logic [CW-1:0] r_n, r_j, r_cnt;
    logic [AW-1:0] r_i;
    t_val          r_s, r_k, r_x, r_vlo, r_vhi, r_res, r_price;
    logic          r_oval;
    logic [63:0]   r_prod;
    logic [ACC_W-1:0] r_acc;

    logic [31:0]   w_ma, w_mb, w_f;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    t_val          w_wdata, w_rdata, w_ex, w_cont, w_scaled;
    logic [ACC_W-1:0] w_sacc;
    logic [CW-1:0] w_nclamp;
    logic          w_cfg_wr, w_acc_in;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_acc_in = s_tvalid && s_tready;
    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_oval;
    assign m_tdata  = r_price;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up    <= ONE_Q30;
            r_down  <= ONE_Q30[30:0];
            r_wup   <= '0;
            r_wdn   <= '0;
            r_steps <= 11'd1;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_UP:    r_up    <= pwdata;
                REG_DOWN:  r_down  <= pwdata[30:0];
                REG_WUP:   r_wup   <= pwdata;
                REG_WDN:   r_wdn   <= pwdata;
                REG_STEPS: r_steps <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_UP:    prdata = r_up;
            REG_DOWN:  prdata = {1'b0, r_down};
            REG_WUP:   prdata = r_wup;
            REG_WDN:   prdata = r_wdn;
            REG_STEPS: prdata = {21'd0, r_steps};
            default:   prdata = '0;
        endcase
    end

    // step count, zero taken as one, capped at MAX_STEPS
    always_comb begin
        if (32'(r_steps) > MAX_STEPS) begin
            w_nclamp = CW'(MAX_STEPS);
        end else if (r_steps == 11'd0) begin
            w_nclamp = CW'(1);
        end else begin
            w_nclamp = CW'(r_steps);
        end
    end

    assign w_ex = (r_k > r_x) ? (r_k - r_x) : '0;
    assign w_f  = r_fsel ? r_up : {1'b0, r_down};

    // scale result: (hi*f << 2) + (lo*f >> 30), saturated
    assign w_sacc   = r_acc + {r_prod, 2'b00};
    assign w_scaled = (w_sacc > ACC_W'(VAL_MAX)) ? VAL_MAX : w_sacc[VAL_W-1:0];
    assign w_cont   = (r_acc > ACC_W'(VAL_MAX)) ? VAL_MAX : r_acc[VAL_W-1:0];

    // shared multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_SCALE) begin
            w_mb = w_f;
            w_ma = (r_ph == 3'd0) ? r_x[31:0] : {16'd0, r_x[47:32]};
        end else if (r_state == S_BL) begin
            unique case (r_ph)
                3'd1:    begin w_ma = r_vhi[31:0];           w_mb = r_wup; end
                3'd2:    begin w_ma = r_vlo[31:0];           w_mb = r_wdn; end
                3'd3:    begin w_ma = {16'd0, r_vhi[47:32]}; w_mb = r_wup; end
                3'd4:    begin w_ma = {16'd0, r_vlo[47:32]}; w_mb = r_wdn; end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = w_ex;
        if (r_state == S_LEAF) begin
            w_we = 1'b1;
        end else if (r_state == S_BL && r_ph == 3'd6) begin
            w_we    = 1'b1;
            w_wdata = (w_cont > w_ex) ? w_cont : w_ex;
        end
    end

    assign w_raddr = (r_state == S_NRD) ? (r_i + AW'(1)) : '0;

    bapp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_STEPS)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_i),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_oval || m_tready)) begin
                r_oval <= 1'b1;
            end else if (m_tready) begin
                r_oval <= 1'b0;
            end
            if (w_we && r_i == '0) begin
                r_res <= w_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_s     <= s_tdata[47:0];
                        r_k     <= s_tdata[95:48];
                        r_x     <= s_tdata[47:0];
                        r_n     <= w_nclamp;
                        r_cnt   <= w_nclamp;
                        r_i     <= '0;
                        r_fsel  <= 1'b0;
                        r_ph    <= '0;
                        r_ret   <= S_LEAF;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    unique case (r_ph)
                        3'd0: r_ph <= 3'd1;
                        3'd1: begin
                            r_acc <= ACC_W'(r_prod[63:30]);
                            r_ph  <= 3'd2;
                        end
                        default: begin
                            r_x  <= w_scaled;
                            r_ph <= '0;
                            if (r_cnt == CW'(1)) begin
                                r_state <= r_ret;
                            end else begin
                                r_cnt <= r_cnt - CW'(1);
                            end
                        end
                    endcase
                end
                S_LEAF: begin
                    if (CW'(r_i) == r_n - CW'(1)) begin
                        if (r_n == CW'(1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_j     <= r_n - CW'(1);
                            r_x     <= r_s;
                            r_cnt   <= r_n - CW'(1);
                            r_fsel  <= 1'b0;
                            r_ret   <= S_LRD0;
                            r_state <= S_SCALE;
                        end
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_cnt   <= CW'(2);
                        r_fsel  <= 1'b1;
                        r_ret   <= S_LEAF;
                        r_state <= S_SCALE;
                    end
                end
                S_LRD0: r_state <= S_L0;
                S_L0: begin
                    r_vlo   <= w_rdata;
                    r_i     <= '0;
                    r_state <= S_NRD;
                end
                S_NRD: begin
                    r_ph    <= '0;
                    r_state <= S_BL;
                end
                S_BL: begin
                    unique case (r_ph)
                        3'd0: begin
                            r_vhi <= w_rdata;
                            r_ph  <= r_ph + 3'd1;
                        end
                        3'd1: r_ph <= r_ph + 3'd1;
                        3'd2: begin
                            r_acc <= ACC_W'(r_prod);
                            r_ph  <= r_ph + 3'd1;
                        end
                        3'd3: begin
                            r_acc <= r_acc + ACC_W'(r_prod);
                            r_ph  <= r_ph + 3'd1;
                        end
                        3'd4: begin
                            r_acc <= ACC_W'(r_acc[ACC_W-1:32]) + ACC_W'(r_prod);
                            r_ph  <= r_ph + 3'd1;
                        end
                        3'd5: begin
                            r_acc <= r_acc + ACC_W'(r_prod);
                            r_ph  <= r_ph + 3'd1;
                        end
                        default: begin
                            r_vlo <= r_vhi;
                            r_ph  <= '0;
                            if (CW'(r_i) + CW'(1) == r_j) begin
                                if (r_j == CW'(1)) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_j     <= r_j - CW'(1);
                                    r_x     <= r_s;
                                    r_cnt   <= r_j - CW'(1);
                                    r_fsel  <= 1'b0;
                                    r_ret   <= S_LRD0;
                                    r_state <= S_SCALE;
                                end
                            end else begin
                                r_i     <= r_i + AW'(1);
                                r_cnt   <= CW'(2);
                                r_fsel  <= 1'b1;
                                r_ret   <= S_NRD;
                                r_state <= S_SCALE;
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    if (!r_oval || m_tready) begin
                        r_price <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a node is never read and written in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_state != S_NRD)
        else $error("node read and write overlap");

    // the scale loop never runs with an empty count
    a_scale_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCALE |-> r_cnt != '0)
        else $error("scale count empty");

    // an interior node always has its upper neighbor inside the level
    a_node_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BL |-> CW'(r_i) < r_j)
        else $error("node index beyond level");

    // a result is only presented from the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_oval) |-> $past(r_state) == S_OUT)
        else $error("result without finished sweep");

endmodule

FILE: sim/testbench.sv
module testbench;
    import bapp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // spot [47:0], strike [95:48]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // price [47:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    binomial_american_put_pricer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the lattice registers
    logic [31:0] up_f;
    logic [30:0] down_f;
    logic [31:0] w_up;
    logic [31:0] w_dn;
    logic [10:0] n_steps;
    t_val        lattice [0:MAX_STEPS_DEF-1];

    logic [95:0] option_q[$];
    t_val        price_q[$];
    int          errors;
    int          snd_idle;
    int          rcv_idle;
    int          hold_req;
    int          hold_cnt;
    int          quiet_cycles;
    bit          s_took;
    bit          nxt_v;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_val scale_q30(t_val x, logic [31:0] f);
        logic [79:0] p;
        p = ({32'd0, x} * {48'd0, f}) >> 30;
        return (p > {32'd0, VAL_MAX}) ? VAL_MAX : p[47:0];
    endfunction

    function automatic t_val mix(t_val a, logic [31:0] wa, t_val b, logic [31:0] wb);
        logic [80:0] acc;
        acc = ({33'd0, a} * {49'd0, wa} + {33'd0, b} * {49'd0, wb}) >> 32;
        return (acc > {33'd0, VAL_MAX}) ? VAL_MAX : acc[47:0];
    endfunction

    function automatic t_val level_spot(t_val s, int j);
        t_val x;
        x = s;
        for (int c = 0; c < j; c++) x = scale_q30(x, {1'b0, down_f});
        return x;
    endfunction

    function automatic t_val put_price(t_val s, t_val k);
        int   n;
        t_val x;
        t_val cont;
        t_val ex;
        n = (n_steps == 0) ? 1 : ((n_steps > MAX_STEPS_DEF) ? MAX_STEPS_DEF : n_steps);
        x = level_spot(s, n);
        for (int i = 0; i < n; i++) begin
            lattice[i] = (k > x) ? k - x : '0;
            x = scale_q30(scale_q30(x, up_f), up_f);
        end
        for (int j = n - 1; j > 0; j--) begin
            x = level_spot(s, j);
            for (int i = 0; i < j; i++) begin
                cont = mix(lattice[i+1], w_up, lattice[i], w_dn);
                ex = (k > x) ? k - x : '0;
                lattice[i] = (cont > ex) ? cont : ex;
                x = scale_q30(scale_q30(x, up_f), up_f);
            end
        end
        return lattice[0];
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_UP:    up_f = val;
            REG_DOWN:  down_f = val[30:0];
            REG_WUP:   w_up = val;
            REG_WDN:   w_dn = val;
            REG_STEPS: n_steps = val[10:0];
            default: ;
        endcase
    endtask

    task automatic set_lattice(logic [31:0] u, logic [31:0] d, logic [31:0] p0,
                               logic [31:0] p1, logic [31:0] n);
        reg_write(REG_UP, u);
        reg_write(REG_DOWN, d);
        reg_write(REG_WUP, p0);
        reg_write(REG_WDN, p1);
        reg_write(REG_STEPS, n);
    endtask

    // append one option to the pending queue
    task automatic add_option(logic [95:0] opt);
        option_q = {option_q, opt};
    endtask

    task automatic drain();
        wait (option_q.size() == 0 && !s_tvalid);
        wait (price_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_val rand48();
        t_val v;
        v = {16'($urandom_range(16'hFFFF, 0)), $urandom()};
        case ($urandom_range(3, 0))
            0: v = v >> $urandom_range(47, 0);
            1: v = {8'd0, v[39:0]};
            default: ;
        endcase
        return v;
    endfunction

    task automatic push_random();
        t_val s;
        t_val k;
        s = rand48();
        case ($urandom_range(3, 0))
            0: k = rand48();
            1: k = s + {16'd0, 8'($urandom_range(255, 0)), 24'd0}
                     - {8'd0, $urandom(), 8'd0};
            default: k = s + 48'({16'd0, $urandom()} * 48'($urandom_range(40, 0)) / 48'd4);
        endcase
        add_option({k, s});
    endtask

    // driver: input side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            nxt_v = s_tvalid && !s_took;
            if (!nxt_v && option_q.size() > 0 && $urandom_range(99, 0) >= snd_idle) begin
                s_tdata <= option_q.pop_front();
                nxt_v = 1'b1;
            end
            s_tvalid <= nxt_v;
        end
    end

    // receiver side, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= rcv_idle);
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        s_took = 1'b0;
        if (i_rst_n) begin
            quiet_cycles++;
            if (s_tvalid && s_tready) begin
                s_took = 1'b1;
                quiet_cycles = 0;
                price_q = {price_q, put_price(s_tdata[47:0], s_tdata[95:48])};
            end
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                if (price_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected price transfer: expected none, actual %h",
                             $time, m_tdata);
                end else if (m_tdata !== price_q[0]) begin
                    errors++;
                    $display("%0t: price mismatch: expected %h, actual %h",
                             $time, price_q[0], m_tdata);
                    void'(price_q.pop_front());
                end else begin
                    void'(price_q.pop_front());
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("binomial_american_put_pricer_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] u;
        errors = 0; snd_idle = 8; rcv_idle = 69;
        hold_req = 0; hold_cnt = 0; quiet_cycles = 0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        up_f = ONE_Q30; down_f = ONE_Q30[30:0]; w_up = '0; w_dn = '0; n_steps = 11'd1;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: single leaf, plain exercise value
        add_option({48'd0, 48'd0});
        add_option({VAL_MAX, 48'd0});
        add_option({48'd0, VAL_MAX});
        add_option({VAL_MAX, VAL_MAX});
        add_option({VAL_MAX - 48'd1, VAL_MAX});
        add_option({48'h0064_0000_0000, 48'h005A_0000_0000});
        drain();

        // zero steps behaves as one
        set_lattice(32'h4100_0000, 32'h3F03_F03F, 32'h7F00_0000, 32'h7E00_0000, 32'd0);
        add_option({48'h0064_0000_0000, 48'h005A_0000_0000});
        add_option({48'h0064_0000_0000, 48'h0070_0000_0000});
        drain();

        // largest up factor and weights: node spot and continuation saturate
        set_lattice(32'hFFFF_FFFF, 32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4);
        add_option({VAL_MAX, 48'h0001_0000_0000});
        add_option({VAL_MAX, VAL_MAX});
        add_option({48'h0000_8000_0000, 48'h4000_0000_0000});
        drain();

        // smallest down factor and weights
        set_lattice(32'h4000_0000, 32'h0000_0000, 32'h0, 32'h0, 32'd3);
        add_option({48'h0064_0000_0000, 48'h0050_0000_0000});
        add_option({VAL_MAX, VAL_MAX});
        drain();

        // typical lattice, moderately many steps
        set_lattice(32'h4147_AE14, 32'h3EBE_BEA8, 32'h7D00_0000, 32'h8100_0000, 32'd48);
        add_option({48'h0064_0000_0000, 48'h0064_0000_0000});
        add_option({48'h006E_0000_0000, 48'h0050_0000_0000});
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph / 4)
                0: begin snd_idle = 8; rcv_idle = 69; end
                1: begin snd_idle = 69; rcv_idle = 8; end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase
            if ($urandom_range(2, 0) == 0) begin
                u = $urandom();
                set_lattice(u, $urandom(), $urandom(), $urandom(), $urandom_range(12, 0));
            end else begin
                u = 32'h4000_0000 + $urandom_range(32'h0800_0000, 0);
                set_lattice(u, 32'((64'h1 << 60) / u), $urandom_range(32'h8800_0000, 0),
                            $urandom_range(32'h8800_0000, 0), $urandom_range(10, 1));
            end
            // receiver stalls while the sender keeps offering
            if (ph == 5) hold_req = 3000;
            for (int it = 0; it < 8; it++) push_random();
            drain();
        end

        // top bits of the step count, with nothing sent afterwards
        reg_write(REG_STEPS, 32'h7FF);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("binomial_american_put_pricer_unit test passed");
        end else begin
            $display("binomial_american_put_pricer_unit test failed");
        end
        $finish;
    end

endmodule
